[design/fcsg_pkg.sv]
// Shared widths and controller/datapath handshake types for the span generator.
`default_nettype none
package fcsg_pkg;
	localparam int COORD_W  = 11;
	localparam int RADIUS_W = 5;
	localparam int SPAN_W   = 12;

	typedef struct packed {
		logic load;
		logic step;
	} fcsg_cmd_t;

	typedef struct packed {
		logic done;
	} fcsg_stat_t;
endpackage
`default_nettype wire

[design/filled_circle_span_generator.sv]
// Top level of the filled circle span generator: controller plus datapath.
//
//   channel   direction   handshake             payload
//   circle    in          start && !busy        center_x, center_y, circle_radius
//   span      out         valid (one cycle)     span_left_x, span_right_x,
//                                               lower_row_y, upper_row_y, last_span
//
// A circle of radius r yields between r + 1 and 2r + 1 spans, one per cycle, set by
// the single-step walk loop in the datapath. busy rises the cycle after start and
// falls with the last step, so a circle occupies its load cycle plus one step per span.
// Each span is registered from its step, and the next circle may be started
// while the last span is still showing. The receiver cannot stall the outputs.
// Reset (arst_n low) returns the controller to idle and clears valid.
`default_nettype none
module filled_circle_span_generator
	import fcsg_pkg::*;
#(
	parameter int MAX_RADIUS = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [COORD_W-1:0]  center_x,
	input  wire logic [COORD_W-1:0]  center_y,
	input  wire logic [RADIUS_W-1:0] circle_radius,
	output logic                     valid,
	output logic signed [SPAN_W-1:0] span_left_x,
	output logic [SPAN_W-1:0]        span_right_x,
	output logic [SPAN_W-1:0]        lower_row_y,
	output logic signed [SPAN_W-1:0] upper_row_y,
	output logic                     last_span
);
	fcsg_cmd_t  cmd;
	fcsg_stat_t stat;

	fcsg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	fcsg_dp #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.center_x      (center_x),
		.center_y      (center_y),
		.circle_radius (circle_radius),
		.valid         (valid),
		.span_left_x   (span_left_x),
		.span_right_x  (span_right_x),
		.lower_row_y   (lower_row_y),
		.upper_row_y   (upper_row_y),
		.last_span     (last_span)
	);
endmodule
`default_nettype wire

[design/fcsg_ctrl.sv]
// Controller: idle/walk sequencing of one circle at a time.
`default_nettype none
module fcsg_ctrl
	import fcsg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire fcsg_stat_t stat,
	output fcsg_cmd_t       cmd,
	output logic            busy
);
	typedef enum logic {ST_IDLE, ST_WALK} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (stat.done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy     = (state_q == ST_WALK);
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.step = (state_q == ST_WALK);
endmodule
`default_nettype wire

[design/fcsg_dp.sv]
// Datapath: walk terms, step arithmetic and the registered span outputs.
`default_nettype none
module fcsg_dp
	import fcsg_pkg::*;
#(
	parameter int MAX_RADIUS = 31
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fcsg_cmd_t               cmd,
	output fcsg_stat_t                   stat,
	input  wire logic [COORD_W-1:0]      center_x,
	input  wire logic [COORD_W-1:0]      center_y,
	input  wire logic [RADIUS_W-1:0]     circle_radius,
	output logic                         valid,
	output logic signed [SPAN_W-1:0]     span_left_x,
	output logic [SPAN_W-1:0]            span_right_x,
	output logic [SPAN_W-1:0]            lower_row_y,
	output logic signed [SPAN_W-1:0]     upper_row_y,
	output logic                         last_span
);
	localparam int RW       = $clog2(MAX_RADIUS + 1);
	localparam int XW       = RW + 2;
	localparam int YW       = RW + 1;
	localparam int EW       = RW + 5;
	localparam int SPAN_CAP = 2 * MAX_RADIUS + 1;
	localparam int CW       = $clog2(SPAN_CAP + 1);
	localparam logic [RADIUS_W-1:0] MAX_R = RADIUS_W'(MAX_RADIUS);

	logic signed [XW-1:0] walk_x_q;
	logic [YW-1:0]        walk_y_q;
	logic signed [EW-1:0] err_q;
	logic [CW-1:0]        cnt_q;
	logic [COORD_W-1:0]   cx_q;
	logic [COORD_W-1:0]   cy_q;

	logic [RADIUS_W-1:0]  r_sat;
	logic [RW-1:0]        r_n;
	logic signed [EW-1:0] x_e, y_e, y1_e, x1_e, err1, err2;
	logic [YW-1:0]        y1;
	logic signed [XW-1:0] x1;
	logic                 y_step, x_step;
	logic [CW-1:0]        cnt_nx;
	logic                 done;
	logic [SPAN_W-1:0]    x_span, y_span, cx_span, cy_span;

	assign r_sat = (circle_radius > MAX_R) ? MAX_R : circle_radius;
	assign r_n   = r_sat[RW-1:0];

	// One walk step: the y update first, then the x test uses the updated error.
	always_comb begin
		x_e    = {{(EW-XW){walk_x_q[XW-1]}}, walk_x_q};
		y_e    = {{(EW-YW){1'b0}}, walk_y_q};
		y_step = (err_q <= y_e);
		y1     = y_step ? walk_y_q + YW'(1) : walk_y_q;
		y1_e   = {{(EW-YW){1'b0}}, y1};
		err1   = y_step ? err_q + {y1_e[EW-2:0], 1'b1} : err_q;
		x_step = (err1 > x_e) || (err1 > y1_e);
		x1     = x_step ? walk_x_q + XW'(1) : walk_x_q;
		x1_e   = {{(EW-XW){x1[XW-1]}}, x1};
		err2   = x_step ? err1 + {x1_e[EW-2:0], 1'b1} : err1;
		cnt_nx = cnt_q + CW'(1);
		done   = (x1 > XW'(0)) || (cnt_nx >= CW'(SPAN_CAP));
	end

	assign stat.done = done;

	assign x_span  = {{(SPAN_W-XW){walk_x_q[XW-1]}}, walk_x_q};
	assign y_span  = {{(SPAN_W-YW){1'b0}}, walk_y_q};
	assign cx_span = {{(SPAN_W-COORD_W){1'b0}}, cx_q};
	assign cy_span = {{(SPAN_W-COORD_W){1'b0}}, cy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q         <= '0;
			cy_q         <= '0;
			walk_x_q     <= '0;
			walk_y_q     <= '0;
			err_q        <= '0;
			cnt_q        <= '0;
			span_left_x  <= '0;
			span_right_x <= '0;
			lower_row_y  <= '0;
			upper_row_y  <= '0;
			last_span    <= 1'b0;
		end else begin
			if (cmd.load) begin
				cx_q     <= center_x;
				cy_q     <= center_y;
				walk_x_q <= XW'(0) - {{(XW-RW){1'b0}}, r_n};
				walk_y_q <= '0;
				err_q    <= EW'(2) - {{(EW-RW-1){1'b0}}, r_n, 1'b0};
				cnt_q    <= '0;
			end else if (cmd.step) begin
				walk_x_q <= x1;
				walk_y_q <= y1;
				err_q    <= err2;
				cnt_q    <= cnt_nx;
			end
			if (cmd.step) begin
				span_left_x  <= cx_span + x_span;
				span_right_x <= cx_span - x_span;
				lower_row_y  <= cy_span + y_span;
				upper_row_y  <= cy_span - y_span;
				last_span    <= done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= cmd.step;
		end
	end
endmodule
`default_nettype wire
